// File: sv/nnsag_pkg.sv
// shared constants, types and register codes of the scaler address generator
`default_nettype none

package nnsag_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_PITCH  = 65536;

    localparam int DIM_W      = 13;   // image dimension register width
    localparam int COORD_W    = 12;   // pixel coordinate width
    localparam int BPP_W      = 3;    // bytes per pixel width
    localparam int PITCH_W    = 17;   // row pitch width
    localparam int OFF_W      = 28;   // byte offset width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int ROW_PROD_W = COORD_W + PITCH_W;
    localparam int COL_PROD_W = COORD_W + BPP_W;
    localparam int DIV_CNT_W  = $clog2(DIM_W);

    localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_BPP        = 3'd4,
        CFG_PITCH      = 3'd5
    } t_cfg_idx;

    // result of one quotient/remainder step computation
    typedef struct packed {
        logic [DIM_W-1:0]   quotient;
        logic [COORD_W-1:0] remainder;
    } t_div_res;

    // coordinates of one destination pixel
    typedef struct packed {
        logic [COORD_W-1:0] dst_col;
        logic [COORD_W-1:0] dst_row;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic               end_of_row;
        logic               end_of_frame;
    } t_coord;

    // coordinates plus the two partial products of the byte offset
    typedef struct packed {
        t_coord                coord;
        logic [ROW_PROD_W-1:0] row_prod;
        logic [COL_PROD_W-1:0] col_prod;
    } t_prod;

    // one result transaction
    typedef struct packed {
        t_coord           coord;
        logic [OFF_W-1:0] src_byte_offset;
    } t_result;

endpackage

`default_nettype wire

// File: sv/nnsag_if.sv
// channel interfaces: pixel tick input, pixel result output, register write
`default_nettype none

interface nnsag_in_if import nnsag_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface nnsag_out_if import nnsag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [OFF_W-1:0]   src_byte_offset;
    logic               end_of_row;
    logic               end_of_frame;

    modport source (output valid, output dst_col, output dst_row, output src_col,
                    output src_row, output src_byte_offset, output end_of_row,
                    output end_of_frame, input ready);
    modport sink   (input valid, input dst_col, input dst_row, input src_col,
                    input src_row, input src_byte_offset, input end_of_row,
                    input end_of_frame, output ready);
endinterface

interface nnsag_cfg_if import nnsag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/nnsag_div.sv
// restoring divider, one quotient bit per cycle, for the scaling steps
`default_nettype none

module nnsag_div import nnsag_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIM_W-1:0] i_dividend,
    input  wire logic [DIM_W-1:0] i_divisor,
    output      logic             o_busy,
    output      t_div_res         o_res
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_quo;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_div;

    logic [DIM_W:0]       w_shift;
    logic                 w_fits;
    logic [DIM_W:0]       w_diff;

    assign w_shift = {r_rem, r_quo[DIM_W-1]};
    assign w_fits  = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= DIM_W'(1);
            r_rem  <= '0;
            r_div  <= DIM_W'(1);
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIM_W-1:0] : w_shift[DIM_W-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder is below the divisor, which never exceeds MAX_DIM
    assign o_busy          = r_busy;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem[COORD_W-1:0];

endmodule

`default_nettype wire

// File: sv/nearest_neighbor_scale_address_gen_top.sv
// nearest-neighbor scaler address generator, top level
//
// i_pix: one transaction per destination pixel; restart=1 rewinds to pixel
//   (0,0) before the pixel is produced
// o_pix: one transaction per input transaction, in raster order, carrying
//   destination and source coordinates, source byte offset and row/frame marks
// i_cfg: register writes (index 0..5: src width/height, dst width/height,
//   bytes per pixel, row pitch); out-of-range values clamp, unknown indexes
//   are dropped and leave the walk alone; a write to a known register
//   rewinds the walk to pixel (0,0)
// throughput: one pixel per cycle while the receiver is ready and no register
//   write or step division is pending; a pixel passes through the state step,
//   product stage and offset sum registers; after a write to a known register
//   the column and row step dividers run, one quotient bit per cycle over 13
//   bits; input and config ready stay low meanwhile
// config is taken only when the pipeline is empty
// reset: registers return to 1,1,1,1,4,4, the walk sits at (0,0), steps are
//   quotient 1 remainder 0, and the pipeline is empty
// when the receiver stalls, the pipeline fills up to three pixels before
//   input ready drops; no transaction is lost or repeated
`default_nettype none

module nearest_neighbor_scale_address_gen_top import nnsag_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    nnsag_in_if.sink     i_pix,
    nnsag_out_if.source  o_pix,
    nnsag_cfg_if.sink    i_cfg
);

    // configuration registers
    logic [DIM_W-1:0]   r_src_width;
    logic [DIM_W-1:0]   r_src_height;
    logic [DIM_W-1:0]   r_dst_width;
    logic [DIM_W-1:0]   r_dst_height;
    logic [BPP_W-1:0]   r_bpp;
    logic [PITCH_W-1:0] r_pitch;
    logic               r_div_start;

    // walk state
    logic [COORD_W-1:0] r_dcol, r_drow, r_scol, r_srow, r_cacc, r_racc;
    logic [COORD_W-1:0] n_dcol, n_drow, n_scol, n_srow, n_cacc, n_racc;

    // pipeline
    logic    r_s1_valid, r_s2_valid, r_out_valid;
    t_coord  r_s1;
    t_prod   r_s2;
    t_result r_out;

    t_div_res w_col_step, w_row_step;
    logic     w_col_busy, w_row_busy, w_busy;
    logic     w_out_en, w_s2_en, w_s1_en;
    logic     w_in_acc, w_cfg_acc;

    // clamped write data
    logic [DIM_W-1:0]      w_dim_val;
    logic [BPP_W-1:0]      w_bpp_val;
    logic [PITCH_W-1:0]    w_pitch_val;
    logic                  w_cfg_known;

    // base state seen by this pixel, after an optional restart
    logic [COORD_W-1:0] b_dcol, b_drow, b_scol, b_srow, b_cacc, b_racc;
    logic               w_last_col, w_last_row;
    logic [DIM_W:0]     w_scol_sum, w_srow_sum;
    logic [DIM_W-1:0]   w_cacc_sum, w_racc_sum;
    logic [DIM_W-1:0]   w_cacc_sub, w_racc_sub;
    t_coord             w_coord;

    // ---------------------------------------------------------------------
    // handshakes: each stage moves when the one after it is empty or moving
    // ---------------------------------------------------------------------
    assign w_busy   = r_div_start | w_col_busy | w_row_busy;
    assign w_out_en = !r_out_valid || o_pix.ready;
    assign w_s2_en  = !r_s2_valid || w_out_en;
    assign w_s1_en  = !r_s1_valid || w_s2_en;

    assign i_pix.ready = w_s1_en && !w_busy && !i_cfg.valid;
    assign w_in_acc    = i_pix.valid && i_pix.ready;

    assign i_cfg.ready = !w_busy && !r_s1_valid && !r_s2_valid && !r_out_valid;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    // ---------------------------------------------------------------------
    // register write decode and clamping
    // ---------------------------------------------------------------------
    always_comb begin
        w_dim_val = i_cfg.data[DIM_W-1:0];
        if (w_dim_val == '0) begin
            w_dim_val = DIM_W'(1);
        end else if (w_dim_val > DIM_W'(MAX_DIM)) begin
            w_dim_val = DIM_W'(MAX_DIM);
        end

        w_bpp_val = i_cfg.data[BPP_W-1:0];
        if (w_bpp_val == '0) begin
            w_bpp_val = BPP_W'(1);
        end else if (w_bpp_val > MAX_BPP) begin
            w_bpp_val = MAX_BPP;
        end

        // zero pitch is kept as is
        w_pitch_val = i_cfg.data[PITCH_W-1:0];
        if (w_pitch_val > PITCH_W'(MAX_PITCH)) begin
            w_pitch_val = PITCH_W'(MAX_PITCH);
        end

        case (i_cfg.index)
            CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH,
            CFG_DST_HEIGHT, CFG_BPP, CFG_PITCH: w_cfg_known = 1'b1;
            default:                            w_cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_W'(1);
            r_src_height <= DIM_W'(1);
            r_dst_width  <= DIM_W'(1);
            r_dst_height <= DIM_W'(1);
            r_bpp        <= MAX_BPP;
            r_pitch      <= PITCH_W'(4);
            r_div_start  <= 1'b0;
        end else begin
            r_div_start <= w_cfg_acc && w_cfg_known;
            if (w_cfg_acc) begin
                case (i_cfg.index)
                    CFG_SRC_WIDTH:  r_src_width  <= w_dim_val;
                    CFG_SRC_HEIGHT: r_src_height <= w_dim_val;
                    CFG_DST_WIDTH:  r_dst_width  <= w_dim_val;
                    CFG_DST_HEIGHT: r_dst_height <= w_dim_val;
                    CFG_BPP:        r_bpp        <= w_bpp_val;
                    CFG_PITCH:      r_pitch      <= w_pitch_val;
                    default:        ;
                endcase
            end
        end
    end

    // step quotient and remainder of both axes, rebuilt after every write to a known register
    nnsag_div u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_src_width),
        .i_divisor  (r_dst_width),
        .o_busy     (w_col_busy),
        .o_res      (w_col_step)
    );

    nnsag_div u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_src_height),
        .i_divisor  (r_dst_height),
        .o_busy     (w_row_busy),
        .o_res      (w_row_step)
    );

    // ---------------------------------------------------------------------
    // walk step: current pixel out, next pixel position in
    // ---------------------------------------------------------------------
    always_comb begin
        if (i_pix.restart) begin
            b_dcol = '0; b_drow = '0; b_scol = '0;
            b_srow = '0; b_cacc = '0; b_racc = '0;
        end else begin
            b_dcol = r_dcol; b_drow = r_drow; b_scol = r_scol;
            b_srow = r_srow; b_cacc = r_cacc; b_racc = r_racc;
        end

        w_last_col = ({1'b0, b_dcol} + DIM_W'(1)) >= r_dst_width;
        w_last_row = ({1'b0, b_drow} + DIM_W'(1)) >= r_dst_height;

        w_coord.dst_col      = b_dcol;
        w_coord.dst_row      = b_drow;
        w_coord.src_col      = b_scol;
        w_coord.src_row      = b_srow;
        w_coord.end_of_row   = w_last_col;
        w_coord.end_of_frame = w_last_col && w_last_row;

        // bresenham style quotient step plus remainder carry
        w_scol_sum = {2'b00, b_scol} + {1'b0, w_col_step.quotient};
        w_cacc_sum = {1'b0, b_cacc} + {1'b0, w_col_step.remainder};
        w_cacc_sub = w_cacc_sum - r_dst_width;
        w_srow_sum = {2'b00, b_srow} + {1'b0, w_row_step.quotient};
        w_racc_sum = {1'b0, b_racc} + {1'b0, w_row_step.remainder};
        w_racc_sub = w_racc_sum - r_dst_height;

        n_dcol = b_dcol; n_drow = b_drow; n_scol = b_scol;
        n_srow = b_srow; n_cacc = b_cacc; n_racc = b_racc;

        if (!w_last_col) begin
            n_dcol = b_dcol + 1'b1;
            if (w_cacc_sum >= r_dst_width) begin
                n_scol = w_scol_sum[COORD_W-1:0] + 1'b1;
                n_cacc = w_cacc_sub[COORD_W-1:0];
            end else begin
                n_scol = w_scol_sum[COORD_W-1:0];
                n_cacc = w_cacc_sum[COORD_W-1:0];
            end
        end else if (!w_last_row) begin
            n_dcol = '0;
            n_scol = '0;
            n_cacc = '0;
            n_drow = b_drow + 1'b1;
            if (w_racc_sum >= r_dst_height) begin
                n_srow = w_srow_sum[COORD_W-1:0] + 1'b1;
                n_racc = w_racc_sub[COORD_W-1:0];
            end else begin
                n_srow = w_srow_sum[COORD_W-1:0];
                n_racc = w_racc_sum[COORD_W-1:0];
            end
        end else begin
            // frame end wraps to the first pixel
            n_dcol = '0; n_drow = '0; n_scol = '0;
            n_srow = '0; n_cacc = '0; n_racc = '0;
        end
    end

    // only writes to known registers rewind the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_cfg_acc && w_cfg_known)) begin
            r_dcol <= '0; r_drow <= '0; r_scol <= '0;
            r_srow <= '0; r_cacc <= '0; r_racc <= '0;
        end else if (w_in_acc) begin
            r_dcol <= n_dcol; r_drow <= n_drow; r_scol <= n_scol;
            r_srow <= n_srow; r_cacc <= n_cacc; r_racc <= n_racc;
        end
    end

    // ---------------------------------------------------------------------
    // offset pipeline: products, then sum
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= w_in_acc;
            end
            if (w_s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_en) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en && w_in_acc) begin
            r_s1 <= w_coord;
        end
        if (w_s2_en && r_s1_valid) begin
            r_s2.coord    <= r_s1;
            r_s2.row_prod <= ROW_PROD_W'(r_s1.src_row) * ROW_PROD_W'(r_pitch);
            r_s2.col_prod <= COL_PROD_W'(r_s1.src_col) * COL_PROD_W'(r_bpp);
        end
        if (w_out_en && r_s2_valid) begin
            // offset wraps at its 28 bits
            r_out.coord           <= r_s2.coord;
            r_out.src_byte_offset <= r_s2.row_prod[OFF_W-1:0]
                                   + OFF_W'(r_s2.col_prod);
        end
    end

    assign o_pix.valid           = r_out_valid;
    assign o_pix.dst_col         = r_out.coord.dst_col;
    assign o_pix.dst_row         = r_out.coord.dst_row;
    assign o_pix.src_col         = r_out.coord.src_col;
    assign o_pix.src_row         = r_out.coord.src_row;
    assign o_pix.src_byte_offset = r_out.src_byte_offset;
    assign o_pix.end_of_row      = r_out.coord.end_of_row;
    assign o_pix.end_of_frame    = r_out.coord.end_of_frame;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_no_pixel_during_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_in_acc)
        else $error("pixel taken while step dividers run");

    a_frame_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (!o_pix.end_of_frame || o_pix.end_of_row))
        else $error("end of frame without end of row");

    a_src_col_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> ({1'b0, o_pix.src_col} < r_src_width))
        else $error("source column outside source image");

    a_src_row_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> ({1'b0, o_pix.src_row} < r_src_height))
        else $error("source row outside source image");

endmodule

`default_nettype wire
